FILE: sv/isrt_pkg.sv
`default_nettype none

package isrt_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DRAIN
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_data    value;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

FILE: sv/isrt_cell.sv
`default_nettype none

module isrt_cell
    import isrt_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctrl i_ctrl,
    input  wire        i_live,
    input  t_data      i_left_value,
    input  wire        i_left_greater,
    input  t_data      i_right_value,
    output t_data      o_value,
    output logic       o_greater
);

    t_data r_value;
    t_data n_value;

    // an empty slot counts as larger than anything, so equal values stay in front
    assign o_greater = !i_live || (r_value > i_ctrl.value);
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (o_greater) begin
                    n_value = i_left_greater ? i_left_value : i_ctrl.value;
                end
            end
            CELL_DRAIN: begin
                n_value = i_right_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

FILE: sv/insertion_sorter.sv
// insertion_sorter: sorts a set of signed 32-bit values into ascending order
//
// input channel (i_valid / o_ready): one value per transaction, i_final_req
// marks the last value of a set. while loading, one transaction is taken
// every cycle; each value is placed into a chain of CAPACITY cells that all
// compare against it at once. values that arrive while the chain is full
// are dropped and the set is flagged; every result of that set then
// carries o_overflow.
// output channel (o_valid / i_ready): after the final transaction the chain
// drains from its low end, one result per cycle while i_ready is high,
// smallest first, with o_end_of_run on the largest. the first result shows
// in the cycle after the final input transaction. no input is taken while
// the set drains. a stalled receiver simply holds the chain: the result
// stays on the ports until taken. reset (i_rst_n low, synchronous) empties
// the chain, clears the overflow flag and returns to loading.
`default_nettype none

module insertion_sorter
    import isrt_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_value,
    input  wire                i_final_req,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic               o_end_of_run,
    output logic               o_overflow
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_flag;
    logic             n_flag;
    t_cell_ctrl       cell_ctrl;

    t_data            cell_value   [CAPACITY];
    logic             cell_greater [CAPACITY];

    logic in_xact;
    logic out_xact;
    logic full;

    assign o_ready        = (r_state == ST_LOAD);
    assign o_valid        = (r_state == ST_DRAIN);
    assign in_xact        = i_valid && o_ready;
    assign out_xact       = o_valid && i_ready;
    assign full           = (r_count == CNT_W'(CAPACITY));
    assign o_sorted_value = cell_value[0];
    assign o_end_of_run   = (r_count == CNT_W'(1));
    assign o_overflow     = r_flag;

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_flag          = r_flag;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = i_value;
        case (r_state)
            ST_LOAD: begin
                if (in_xact) begin
                    if (full) begin
                        n_flag = 1'b1;
                    end else begin
                        cell_ctrl.op = CELL_INSERT;
                        n_count      = r_count + CNT_W'(1);
                    end
                    if (i_final_req) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_xact) begin
                    cell_ctrl.op = CELL_DRAIN;
                    n_count      = r_count - CNT_W'(1);
                    if (o_end_of_run) begin
                        n_state = ST_LOAD;
                        n_flag  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_data left_value;
        logic  left_greater;
        t_data right_value;

        if (i == 0) begin : g_first
            assign left_value   = i_value;
            assign left_greater = 1'b0;
        end else begin : g_mid
            assign left_value   = cell_value[i-1];
            assign left_greater = cell_greater[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
        end else begin : g_inner
            assign right_value = cell_value[i+1];
        end

        isrt_cell u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (cell_ctrl),
            .i_live         (r_count > CNT_W'(i)),
            .i_left_value   (left_value),
            .i_left_greater (left_greater),
            .i_right_value  (right_value),
            .o_value        (cell_value[i]),
            .o_greater      (cell_greater[i])
        );
    end

`ifndef ASSERT_OFF
    a_drain_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0))
        else $error("draining with an empty chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && full) |=> r_flag)
        else $error("dropped value did not set overflow");

    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && i_final_req) |=> o_valid)
        else $error("final transaction did not start the drain");

    a_last_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xact && o_end_of_run) |=> (o_ready && r_count == '0 && !r_flag))
        else $error("chain not cleared after the last result");
`endif

endmodule

`default_nettype wire
